[src/sdcp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcp_pkg
// Shared types and constants of the serial debug command parser.
// ----------------------------------------------------------------------------
package sdcp_pkg;

  // number of enable bits or motors that the commands may address
  localparam logic [3:0] GROUND_COUNT   = 4'd8;
  localparam logic [3:0] DISTANCE_COUNT = 4'd8;
  localparam logic [3:0] MOTOR_COUNT    = 4'd8;

  // depth of the queues between front, back and the result ports
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_BANG  = 8'h21;
  localparam logic [7:0] CHAR_G     = 8'h47;
  localparam logic [7:0] CHAR_D     = 8'h44;
  localparam logic [7:0] CHAR_M     = 8'h4D;
  localparam logic [7:0] CHAR_E     = 8'h45;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  typedef enum logic [2:0] {
    LET_NONE,
    LET_G,
    LET_D,
    LET_M,
    LET_E
  } letter_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_G_IDX,
    PH_G_VAL,
    PH_D_IDX,
    PH_D_VAL,
    PH_M_ARG,
    PH_E_ID,
    PH_E_SIGN,
    PH_E_D1,
    PH_E_D2,
    PH_E_D3
  } phase_t;

  // one classified byte, as passed from the front to the back
  typedef struct packed {
    logic [7:0]        raw;
    logic              is_star;
    logic              is_bang;
    logic              is_zero;
    logic              is_minus;
    letter_t           letter;
    logic signed [8:0] digit;
  } token_t;

  // token channel between front and back
  typedef struct packed {
    logic   valid;
    token_t token;
  } tok_chan_t;

  typedef struct packed {
    logic [7:0]         ground_mask;
    logic [7:0]         distance_mask;
    logic               manual_mode;
    logic               motor_write;
    logic [2:0]         motor_index;
    logic signed [15:0] motor_value;
    logic               reset_request;
    logic               wait_release;
  } result_t;

endpackage

[src/sdcp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcp_front
// Classifies received bytes and holds them in a short token queue.
// ----------------------------------------------------------------------------
module sdcp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [7:0]        rx_byte,
  output logic              full,
  output sdcp_pkg::tok_chan_t tok,
  input  logic              tok_pop
);
  import sdcp_pkg::*;

  token_t              entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  token_t              cls;
  logic                do_push;
  logic                do_pop;

  always_comb begin
    cls.raw      = rx_byte;
    cls.is_star  = (rx_byte == CHAR_STAR);
    cls.is_bang  = (rx_byte == CHAR_BANG);
    cls.is_zero  = (rx_byte == CHAR_ZERO);
    cls.is_minus = (rx_byte == CHAR_MINUS);
    cls.digit    = $signed({1'b0, rx_byte}) - $signed({1'b0, CHAR_ZERO});
    case (rx_byte)
      CHAR_G:  cls.letter = LET_G;
      CHAR_D:  cls.letter = LET_D;
      CHAR_M:  cls.letter = LET_M;
      CHAR_E:  cls.letter = LET_E;
      default: cls.letter = LET_NONE;
    endcase
  end

  assign full      = (count == QCNT_W'(QDEPTH));
  assign do_push   = push && !full;
  assign do_pop    = tok_pop && tok.valid;
  assign tok.valid = (count != '0);
  assign tok.token = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/sdcp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcp_back
// Command parser state machine and the result queue toward the output ports.
// ----------------------------------------------------------------------------
module sdcp_back (
  input  logic                clk,
  input  logic                rst,
  input  sdcp_pkg::tok_chan_t tok,
  output logic                tok_pop,
  output logic                empty,
  input  logic                pop,
  output sdcp_pkg::result_t   res
);
  import sdcp_pkg::*;

  phase_t             phase, phase_next;
  logic [7:0]         held_index, held_index_next;
  logic               held_negative, held_negative_next;
  logic signed [15:0] acc, acc_next;
  logic [7:0]         ground_bits, ground_bits_next;
  logic [7:0]         distance_bits, distance_bits_next;
  logic               manual_flag, manual_flag_next;

  result_t            entries [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_pop;
  logic               step;
  result_t            r;
  token_t             t;
  logic signed [15:0] acc_step;
  logic signed [15:0] digit_ext;

  function automatic phase_t take_letter(input letter_t l, input logic manual);
    case (l)
      LET_G:   return PH_G_IDX;
      LET_D:   return PH_D_IDX;
      LET_M:   return PH_M_ARG;
      LET_E:   return manual ? PH_E_ID : PH_IDLE;
      default: return PH_IDLE;
    endcase
  endfunction

  function automatic logic index_ok(input logic [7:0] b, input logic [3:0] cnt);
    logic [7:0] off;
    off = b - CHAR_ZERO;
    return (b >= CHAR_ZERO) && (off < {4'b0000, cnt});
  endfunction

  function automatic logic [7:0] apply_bit(input logic [7:0] mask, input logic [7:0] idx_b,
                                           input logic clear, input logic [3:0] cnt);
    logic [2:0] pos;
    logic [7:0] sel;
    pos = 3'(idx_b - CHAR_ZERO);
    sel = 8'b1 << pos;
    if (!index_ok(idx_b, cnt)) begin
      return mask;
    end
    return clear ? (mask & ~sel) : (mask | sel);
  endfunction

  assign t         = tok.token;
  assign do_pop    = pop && !empty;
  assign empty     = (count == '0);
  assign tok_pop   = (count != QCNT_W'(QDEPTH)) || do_pop;
  assign step      = tok.valid && tok_pop;
  assign digit_ext = {{7{t.digit[8]}}, t.digit};
  // acc * 10 + digit
  assign acc_step  = (acc <<< 3) + (acc <<< 1) + digit_ext;
  assign res       = entries[rd_ptr];

  always_comb begin
    phase_next         = phase;
    held_index_next    = held_index;
    held_negative_next = held_negative;
    acc_next           = acc;
    ground_bits_next   = ground_bits;
    distance_bits_next = distance_bits;
    manual_flag_next   = manual_flag;
    r                  = '0;

    if (t.is_star) begin
      r.reset_request = 1'b1;
      phase_next      = PH_IDLE;
    end else begin
      r.wait_release = t.is_bang;
      case (phase)
        PH_G_IDX: begin
          held_index_next = t.raw;
          phase_next      = PH_G_VAL;
        end
        PH_G_VAL: begin
          ground_bits_next = apply_bit(ground_bits, held_index, t.is_zero, GROUND_COUNT);
          phase_next       = PH_IDLE;
        end
        PH_D_IDX: begin
          held_index_next = t.raw;
          phase_next      = PH_D_VAL;
        end
        PH_D_VAL: begin
          distance_bits_next = apply_bit(distance_bits, held_index, t.is_zero,
                                         DISTANCE_COUNT);
          phase_next         = PH_IDLE;
        end
        PH_M_ARG: begin
          // the argument byte is also taken as the next command letter
          manual_flag_next = !t.is_zero;
          phase_next       = take_letter(t.letter, !t.is_zero);
        end
        PH_E_ID: begin
          held_index_next = t.raw;
          phase_next      = PH_E_SIGN;
        end
        PH_E_SIGN: begin
          held_negative_next = t.is_minus;
          acc_next           = '0;
          phase_next         = PH_E_D1;
        end
        PH_E_D1: begin
          acc_next   = acc_step;
          phase_next = PH_E_D2;
        end
        PH_E_D2: begin
          acc_next   = acc_step;
          phase_next = PH_E_D3;
        end
        PH_E_D3: begin
          acc_next   = acc_step;
          phase_next = PH_IDLE;
          if (index_ok(held_index, MOTOR_COUNT)) begin
            r.motor_write = 1'b1;
            r.motor_index = 3'(held_index - CHAR_ZERO);
            r.motor_value = held_negative ? -acc_step : acc_step;
          end
        end
        default: begin
          phase_next = take_letter(t.letter, manual_flag);
        end
      endcase
    end

    r.ground_mask   = ground_bits_next;
    r.distance_mask = distance_bits_next;
    r.manual_mode   = manual_flag_next;
  end

  always_ff @(posedge clk) begin
    if (step) begin
      entries[wr_ptr] <= r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_index    <= '0;
      held_negative <= 1'b0;
      acc           <= '0;
    end else if (step) begin
      held_index    <= held_index_next;
      held_negative <= held_negative_next;
      acc           <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      ground_bits   <= '0;
      distance_bits <= '0;
      manual_flag   <= 1'b0;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      count         <= '0;
    end else begin
      if (step) begin
        phase         <= phase_next;
        ground_bits   <= ground_bits_next;
        distance_bits <= distance_bits_next;
        manual_flag   <= manual_flag_next;
        wr_ptr        <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (step && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !step) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/serial_debug_command_parser_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_debug_command_parser_core
// Decodes single-letter debug commands from a serial byte stream.
//
//   channel   handshake          payload
//   input     push / full        rx_byte
//   result    pop / empty        masks, mode, motor write, pulses
//
// One byte per cycle sustained while the result queue has room or is popped; a
// result is on the result ports, and can be popped, once its byte has passed
// the classify queue and then the parser step.
// Synchronous reset clears the parser, masks, mode and both queues.
// Each side stalls on its own: full rises only when the two-entry token
// queue fills behind a stalled result queue.
// ----------------------------------------------------------------------------
module serial_debug_command_parser_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         rx_byte,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         ground_mask,
  output logic [7:0]         distance_mask,
  output logic               manual_mode,
  output logic               motor_write,
  output logic [2:0]         motor_index,
  output logic signed [15:0] motor_value,
  output logic               reset_request,
  output logic               wait_release
);
  import sdcp_pkg::*;

  tok_chan_t tok;
  logic      tok_pop;
  result_t   res;

  sdcp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .rx_byte (rx_byte),
    .full    (full),
    .tok     (tok),
    .tok_pop (tok_pop)
  );

  sdcp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .tok     (tok),
    .tok_pop (tok_pop),
    .empty   (empty),
    .pop     (pop),
    .res     (res)
  );

  assign ground_mask   = res.ground_mask;
  assign distance_mask = res.distance_mask;
  assign manual_mode   = res.manual_mode;
  assign motor_write   = res.motor_write;
  assign motor_index   = res.motor_index;
  assign motor_value   = res.motor_value;
  assign reset_request = res.reset_request;
  assign wait_release  = res.wait_release;

  // motor commands only complete in manual mode
  assert property (@(posedge clk) disable iff (rst)
    (!empty && motor_write) |-> manual_mode)
    else $error("motor write outside manual mode");

  assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(reset_request && wait_release))
    else $error("restart and release pulses together");

  assert property (@(posedge clk) disable iff (rst)
    (!empty && !motor_write) |-> (motor_index == 3'd0 && motor_value == 16'sd0))
    else $error("motor fields set without a motor write");

  assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not cleared by reset");

endmodule
